FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the checker modules
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/cfrb_pkg.sv
// shared types, constants and helper functions of the can frame byte ring buffer
// no dependencies; used by every module of the block
package cfrb_pkg;

    localparam int BUF_SIZE  = 256;
    localparam int IDX_W     = $clog2(BUF_SIZE);
    localparam int MAX_FRAME = 8;
    localparam int LANES     = 8;
    localparam int LANE_W    = $clog2(LANES);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_PEEK  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] frame_len;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
    } item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       byte_valid;
        logic [7:0] fill_level;
        logic       overrun;
    } result_t;

    // one lane's view of one payload byte
    typedef struct packed {
        logic       en;
        idx_t       addr;
        logic [7:0] data;
    } lane_t;

    // what the merge stage derives from all lanes
    typedef struct packed {
        logic overrun;
        idx_t next_wr;
    } merge_t;

    // slot after i, wrapping at the end of the buffer
    function automatic idx_t next_slot(idx_t i);
        if (32'(i) + 32'd1 >= 32'(BUF_SIZE)) begin
            return '0;
        end
        return idx_t'(32'(i) + 32'd1);
    endfunction

    // unread bytes: (wr - lr - 1) mod size
    function automatic idx_t fill_of(idx_t wr, idx_t lr);
        logic [IDX_W:0] d;
        if (wr > lr) begin
            d = {1'b0, wr} - {1'b0, lr} - (IDX_W+1)'(1);
        end else begin
            d = {1'b0, wr} + (IDX_W+1)'(BUF_SIZE) - {1'b0, lr} - (IDX_W+1)'(1);
        end
        return d[IDX_W-1:0];
    endfunction

    // fill level as reported, clipped to eight bits
    function automatic logic [7:0] sat8(idx_t f);
        if (32'(f) > 32'd255) begin
            return 8'hFF;
        end
        return 8'(f);
    endfunction

endpackage

FILE: hw/rtl/cfrb_lane.sv
// one byte lane: slot address and enable for one payload byte of a frame
// depends on cfrb_pkg
module cfrb_lane (
    input  cfrb_pkg::idx_t               base,
    input  logic [cfrb_pkg::LANE_W-1:0]  lane_num,
    input  logic [3:0]                   len,
    input  logic [7:0]                   data,
    output cfrb_pkg::lane_t              lane
);
    import cfrb_pkg::*;

    logic [IDX_W:0] sum;

    always_comb
    begin
        sum = {1'b0, base} + (IDX_W+1)'(lane_num);
        if (sum >= (IDX_W+1)'(BUF_SIZE)) begin
            sum = sum - (IDX_W+1)'(BUF_SIZE);
        end
        lane.en   = 4'(lane_num) < len;
        lane.addr = sum[IDX_W-1:0];
        lane.data = data;
    end

endmodule

FILE: hw/rtl/cfrb_merge.sv
// merge stage: counts the active lanes, checks free space, finds the new write pointer
// depends on cfrb_pkg
module cfrb_merge (
    input  cfrb_pkg::idx_t   wr,
    input  cfrb_pkg::idx_t   lr,
    input  cfrb_pkg::lane_t  lanes [cfrb_pkg::LANES],
    output cfrb_pkg::merge_t merged
);
    import cfrb_pkg::*;

    logic [LANE_W:0] count;
    idx_t            free_slots;
    idx_t            last_addr;

    always_comb
    begin
        count = '0;
        for (int i = 0; i < LANES; i++) begin
            count = count + (LANE_W+1)'(lanes[i].en);
        end
        free_slots     = idx_t'(BUF_SIZE - 1) - fill_of(wr, lr);
        last_addr      = lanes[LANE_W'(count - (LANE_W+1)'(1))].addr;
        merged.overrun = 32'(count) > 32'(free_slots);
        merged.next_wr = (count == '0) ? wr : next_slot(last_addr);
    end

endmodule

FILE: hw/rtl/can_frame_byte_ring_buffer.sv
// top level of the can frame byte ring buffer: control, pointers and byte storage
// depends on cfrb_pkg, cfrb_lane and cfrb_merge
//
// A byte ring buffer fed with can frame payloads. Raise start with an item while
// busy is low; the item is taken at that clock edge. op selects write (store
// frame_len bytes, byte_0 first, length clipped to eight), read (pop one byte)
// or peek (show the next byte and keep it); code three does nothing. Exactly one
// result comes back per item, on result for a single cycle with done high, and
// it cannot be held off: capture it when done is high. fill_level is the count
// of unread bytes after the item and overrun marks a write that did not fit;
// such a write still overwrites the oldest data. One slot always stays unused,
// so the buffer holds at most 255 bytes. A write stores its bytes one per cycle
// through the single write port of the byte memory, then forms the result and
// shows it with done high; a read or peek does the registered memory read, then
// forms the result and shows it; a zero length write or a no-op only forms the
// result and shows it. busy drops in the cycle done is shown, so the next item
// may be started right then. After reset the buffer is empty and ready at once;
// the byte memory needs no clearing.
module can_frame_byte_ring_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cfrb_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output cfrb_pkg::result_t result
);
    import cfrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_FINISH
    } state_t;

    // control state
    state_t            state_reg;
    logic [LANE_W-1:0] cnt_reg;
    logic [3:0]        len_reg;
    logic [1:0]        op_reg;
    logic              hit_reg;
    logic              ovr_reg;
    idx_t              wr_reg;
    idx_t              lr_reg;
    logic              done_reg;
    result_t           result_reg;

    // payload captured at the accepting edge
    lane_t             lane_reg [LANES];
    idx_t              next_wr_reg;
    idx_t              rd_addr_reg;

    // byte storage, contents undefined until written
    logic [7:0]        mem [BUF_SIZE];
    logic [7:0]        rdata_reg;

    logic [3:0]        len_sat;
    logic [7:0]        item_bytes [LANES];
    lane_t             lane_out [LANES];
    merge_t            merge_out;
    idx_t              fill_now;
    idx_t              rd_addr_next;
    lane_t             lane_sel;
    logic              accept;
    logic              is_rd;

    assign accept       = start && (state_reg == S_IDLE);
    assign len_sat      = (item.frame_len > 4'(MAX_FRAME)) ? 4'(MAX_FRAME) : item.frame_len;
    assign fill_now     = fill_of(wr_reg, lr_reg);
    assign rd_addr_next = next_slot(lr_reg);
    assign is_rd        = (item.op == OP_READ) || (item.op == OP_PEEK);
    assign lane_sel     = lane_reg[cnt_reg];

    assign item_bytes[0] = item.byte_0;
    assign item_bytes[1] = item.byte_1;
    assign item_bytes[2] = item.byte_2;
    assign item_bytes[3] = item.byte_3;
    assign item_bytes[4] = item.byte_4;
    assign item_bytes[5] = item.byte_5;
    assign item_bytes[6] = item.byte_6;
    assign item_bytes[7] = item.byte_7;

    // every lane finds the slot of its byte at the same time
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        cfrb_lane u_lane (
            .base     (wr_reg),
            .lane_num (LANE_W'(g)),
            .len      (len_sat),
            .data     (item_bytes[g]),
            .lane     (lane_out[g])
        );
    end

    // lanes combine into overrun flag and new write pointer
    cfrb_merge u_merge (
        .wr     (wr_reg),
        .lr     (lr_reg),
        .lanes  (lane_out),
        .merged (merge_out)
    );

    // sequencer: state, pointers and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            len_reg    <= '0;
            op_reg     <= OP_WRITE;
            hit_reg    <= 1'b0;
            ovr_reg    <= 1'b0;
            wr_reg     <= '0;
            lr_reg     <= idx_t'(BUF_SIZE - 1);
            done_reg   <= 1'b0;
            result_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        op_reg  <= item.op;
                        len_reg <= len_sat;
                        cnt_reg <= '0;
                        ovr_reg <= (item.op == OP_WRITE) && merge_out.overrun;
                        hit_reg <= is_rd && (fill_now != '0);
                        if ((item.op == OP_WRITE) && (len_sat != 4'd0)) begin
                            state_reg <= S_WRITE;
                        end else if (is_rd) begin
                            state_reg <= S_READ;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_WRITE: begin
                    // one byte per cycle into the memory
                    cnt_reg <= cnt_reg + LANE_W'(1);
                    if (4'(cnt_reg) + 4'd1 == len_reg) begin
                        wr_reg    <= next_wr_reg;
                        state_reg <= S_FINISH;
                    end
                end
                S_READ: begin
                    // memory data lands in rdata_reg at this edge
                    if (hit_reg && (op_reg == OP_READ)) begin
                        lr_reg <= rd_addr_reg;
                    end
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    done_reg              <= 1'b1;
                    result_reg.read_byte  <= hit_reg ? rdata_reg : 8'd0;
                    result_reg.byte_valid <= hit_reg;
                    result_reg.fill_level <= sat8(fill_now);
                    result_reg.overrun    <= ovr_reg;
                    state_reg             <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // lane results and addresses held for the write and read sequences
    always_ff @(posedge clk)
    begin
        if (accept) begin
            lane_reg    <= lane_out;
            next_wr_reg <= merge_out.next_wr;
            rd_addr_reg <= rd_addr_next;
        end
    end

    // byte memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WRITE) && lane_sel.en) begin
            mem[lane_sel.addr] <= lane_sel.data;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hw/rtl/cfrb_checker.sv
// port level checks of the can frame byte ring buffer, bound to the top level
// depends on cfrb_pkg and assert_macros.svh
`include "assert_macros.svh"

module cfrb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input cfrb_pkg::result_t result
);
    import cfrb_pkg::*;

    // a transfer in makes the block busy on the next cycle
    `ASSERT_CLK(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted item did not raise busy")

    // a result is shown only once the block is free again
    `ASSERT_CLK(a_done_idle, clk, rst_n, done |-> !busy, "result shown while busy")

    // every result strobe lasts one cycle
    `ASSERT_CLK(a_done_single, clk, rst_n, done |=> !done, "result strobe held for two cycles")

    // a write never reports a byte, a read never reports overrun
    `ASSERT_NEVER(a_valid_ovr, clk, rst_n, done && result.byte_valid && result.overrun, "byte valid together with overrun")

endmodule

bind can_frame_byte_ring_buffer cfrb_checker u_cfrb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
